/* src/triangle_transform_cull_project_top_defines.svh */
// Assertion macros shared by the triangle transform block.
`ifndef TRIANGLE_TRANSFORM_CULL_PROJECT_TOP_DEFINES_SVH
`define TRIANGLE_TRANSFORM_CULL_PROJECT_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define TCP_ASSERT_NOW(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("check failed");
`define TCP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("check failed");
`else
`define TCP_ASSERT_NOW(lbl, cond)
`define TCP_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

/* src/tcp_pkg.sv */
package tcp_pkg;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
  } tcp_in_t;

  typedef struct packed {
    logic signed [31:0] a_px;
    logic signed [31:0] a_py;
    logic signed [31:0] b_px;
    logic signed [31:0] b_py;
    logic signed [31:0] c_px;
    logic signed [31:0] c_py;
    logic               visible;
  } tcp_out_t;

  typedef struct packed {
    logic signed [17:0] cos_spin;
    logic signed [17:0] sin_spin;
    logic signed [17:0] cos_tilt;
    logic signed [17:0] sin_tilt;
    logic        [30:0] x_scale;
    logic        [30:0] y_scale;
    logic signed [31:0] push_depth;
  } tcp_cfg_t;

  typedef enum logic [2:0] {
    CFG_COS_SPIN   = 3'd0,
    CFG_SIN_SPIN   = 3'd1,
    CFG_COS_TILT   = 3'd2,
    CFG_SIN_TILT   = 3'd3,
    CFG_X_SCALE    = 3'd4,
    CFG_Y_SCALE    = 3'd5,
    CFG_PUSH_DEPTH = 3'd6
  } tcp_cfg_idx_t;

  localparam int XF_LAT    = 4;
  localparam int CULL_LAT  = 5;
  localparam int DIV_STEPS = 32;
  localparam int PROJ_LAT  = DIV_STEPS + 4;
  localparam int PIPE_LAT  = XF_LAT + PROJ_LAT;

  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7fffffff;
    else if (v < S32_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* src/tcp_xform.sv */
module tcp_xform #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  tcp_pkg::tcp_cfg_t  cfg,
  input  logic signed [31:0] x,
  input  logic signed [31:0] y,
  input  logic signed [31:0] z,
  output logic signed [31:0] xo,
  output logic signed [31:0] yo,
  output logic signed [31:0] zo
);
  import tcp_pkg::*;

  localparam logic signed [52:0] HALF = 53'sd1 <<< (FRAC_BITS - 1);

  logic signed [49:0] xc_r, ys_r, xs_r, yc_r;
  logic signed [31:0] z1_r, z2_r;
  logic signed [31:0] x1_r, y1_r, x3_r;
  logic signed [49:0] yct_r, zst_r, yst_r, zct_r;
  logic signed [31:0] x1_nxt, y1_nxt, y2_nxt, z2_nxt, zo_nxt;
  logic signed [31:0] xo_r, yo_r, zo_r;
  logic signed [52:0] s0, s1, s2, s3;

  always_comb begin
    s0 = 53'(xc_r) - 53'(ys_r) + HALF;
    s1 = 53'(xs_r) + 53'(yc_r) + HALF;
    x1_nxt = sat32(66'(s0 >>> FRAC_BITS));
    y1_nxt = sat32(66'(s1 >>> FRAC_BITS));
    s2 = 53'(yct_r) - 53'(zst_r) + HALF;
    s3 = 53'(yst_r) + 53'(zct_r) + HALF;
    y2_nxt = sat32(66'(s2 >>> FRAC_BITS));
    z2_nxt = sat32(66'(s3 >>> FRAC_BITS));
    zo_nxt = sat32(66'(z2_nxt) + 66'(cfg.push_depth));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // rotate about Z
      xc_r <= 50'(x) * 50'(cfg.cos_spin);
      ys_r <= 50'(y) * 50'(cfg.sin_spin);
      xs_r <= 50'(x) * 50'(cfg.sin_spin);
      yc_r <= 50'(y) * 50'(cfg.cos_spin);
      z1_r <= z;
      x1_r <= x1_nxt;
      y1_r <= y1_nxt;
      z2_r <= z1_r;
      // rotate about X
      yct_r <= 50'(y1_r) * 50'(cfg.cos_tilt);
      zst_r <= 50'(z2_r) * 50'(cfg.sin_tilt);
      yst_r <= 50'(y1_r) * 50'(cfg.sin_tilt);
      zct_r <= 50'(z2_r) * 50'(cfg.cos_tilt);
      x3_r  <= x1_r;
      xo_r  <= x3_r;
      yo_r  <= y2_nxt;
      zo_r  <= zo_nxt;
    end
  end

  assign xo = xo_r;
  assign yo = yo_r;
  assign zo = zo_r;

endmodule

/* src/tcp_cull.sv */
module tcp_cull (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a [3],
  input  logic signed [31:0] b [3],
  input  logic signed [31:0] c [3],
  output logic               vis
);
  import tcp_pkg::*;

  logic signed [63:0] m_r [6];
  logic signed [64:0] k_r [3];
  logic signed [31:0] a1_r [3];
  logic signed [31:0] a2_r [3];
  logic signed [64:0] lo_r [3];
  logic signed [64:0] hi_r [3];
  logic signed [97:0] t_r [3];
  logic signed [97:0] sum_nxt;
  logic               vis_r;

  assign sum_nxt = t_r[0] + t_r[1] + t_r[2];

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= 64'(b[1]) * 64'(c[2]);
      m_r[1] <= 64'(b[2]) * 64'(c[1]);
      m_r[2] <= 64'(b[0]) * 64'(c[2]);
      m_r[3] <= 64'(b[2]) * 64'(c[0]);
      m_r[4] <= 64'(b[0]) * 64'(c[1]);
      m_r[5] <= 64'(b[1]) * 64'(c[0]);
      a1_r   <= a;
      // cofactors of a along the first row
      k_r[0] <= 65'(m_r[0]) - 65'(m_r[1]);
      k_r[1] <= 65'(m_r[3]) - 65'(m_r[2]);
      k_r[2] <= 65'(m_r[4]) - 65'(m_r[5]);
      a2_r   <= a1_r;
      for (int j = 0; j < 3; j++) begin
        lo_r[j] <= 65'(a2_r[j]) * 65'($signed({1'b0, k_r[j][31:0]}));
        hi_r[j] <= 65'(a2_r[j]) * 65'($signed(k_r[j][64:32]));
        t_r[j]  <= (98'(hi_r[j]) <<< 32) + 98'(lo_r[j]);
      end
      vis_r <= sum_nxt[97];
    end
  end

  assign vis = vis_r;

endmodule

/* src/tcp_proj.sv */
module tcp_proj #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] c,
  input  logic        [30:0] scale,
  input  logic signed [31:0] d,
  output logic signed [31:0] q
);
  import tcp_pkg::*;

  localparam logic signed [64:0] HALF = 65'sd1 <<< (FRAC_BITS - 1);

  logic signed [63:0] p_r;
  logic signed [31:0] d_r;
  logic        [63:0] np_r;
  logic        [31:0] nd_r;
  logic               neg_r, zero_r;
  logic signed [31:0] rnd_r;
  logic signed [64:0] rs;

  // divider stage array; entry 0 is loaded from the magnitudes
  logic [31:0]        rem_r  [DIV_STEPS+1];
  logic [31:0]        low_r  [DIV_STEPS+1];
  logic [31:0]        quo_r  [DIV_STEPS+1];
  logic [31:0]        nds_r  [DIV_STEPS+1];
  logic               negs_r [DIV_STEPS+1];
  logic               zers_r [DIV_STEPS+1];
  logic               ovfs_r [DIV_STEPS+1];
  logic signed [31:0] rnds_r [DIV_STEPS+1];
  logic signed [31:0] q_r, q_nxt;

  assign rs = 65'(p_r) + HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= 64'(c) * 64'($signed({1'b0, scale}));
      d_r    <= d;
      zero_r <= (d_r == 32'sd0);
      neg_r  <= p_r[63] ^ d_r[31];
      np_r   <= p_r[63] ? 64'(-p_r) : 64'(p_r);
      nd_r   <= d_r[31] ? 32'(-d_r) : 32'(d_r);
      rnd_r  <= sat32(66'(rs >>> FRAC_BITS));
      rem_r[0]  <= np_r[63:32];
      low_r[0]  <= np_r[31:0];
      quo_r[0]  <= '0;
      nds_r[0]  <= nd_r;
      negs_r[0] <= neg_r;
      zers_r[0] <= zero_r;
      ovfs_r[0] <= (np_r[63:32] >= nd_r);
      rnds_r[0] <= rnd_r;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [32:0] t;
    logic [32:0] diff;
    logic        take;
    always_comb begin
      t    = {rem_r[i], low_r[i][31]};
      diff = t - {1'b0, nds_r[i]};
      take = (t >= {1'b0, nds_r[i]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]  <= take ? diff[31:0] : t[31:0];
        low_r[i+1]  <= {low_r[i][30:0], 1'b0};
        quo_r[i+1]  <= {quo_r[i][30:0], take};
        nds_r[i+1]  <= nds_r[i];
        negs_r[i+1] <= negs_r[i];
        zers_r[i+1] <= zers_r[i];
        ovfs_r[i+1] <= ovfs_r[i];
        rnds_r[i+1] <= rnds_r[i];
      end
    end
  end

  always_comb begin
    if (zers_r[DIV_STEPS]) begin
      q_nxt = rnds_r[DIV_STEPS];
    end else if (ovfs_r[DIV_STEPS]) begin
      q_nxt = negs_r[DIV_STEPS] ? 32'sh80000000 : 32'sh7fffffff;
    end else if (negs_r[DIV_STEPS]) begin
      q_nxt = quo_r[DIV_STEPS][31] ? 32'sh80000000 : -$signed(quo_r[DIV_STEPS]);
    end else begin
      q_nxt = quo_r[DIV_STEPS][31] ? 32'sh7fffffff : $signed(quo_r[DIV_STEPS]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

/* src/triangle_transform_cull_project_top.sv */
// Each beat passes 40 pipeline stages plus the output register.
// One triangle per cycle while in_ready is high; each lane's 32-step divider sets the depth.
// Output stalls are absorbed by a one-entry skid register; in_ready drops only while it is full.
// Synchronous active-low reset clears valid bits and loads configuration defaults.
`include "triangle_transform_cull_project_top_defines.svh"
module triangle_transform_cull_project_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcp_pkg::tcp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tcp_pkg::tcp_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_idx,
  input  logic [31:0]       cfg_wdata
);
  import tcp_pkg::*;

  localparam logic [63:0] ONE      = 64'd1 << FRAC_BITS;
  localparam logic [63:0] PUSH_RST = (64'd5 * ONE) / 64'd2;
  localparam int          VIS_DLY  = PROJ_LAT - CULL_LAT;

  tcp_cfg_t cfg_r;
  logic     en;
  logic [PIPE_LAT-1:0] vld_r;
  logic [VIS_DLY-1:0]  vis_d_r;
  logic     vis0;
  logic signed [31:0] vx [3], vy [3], vz [3];
  logic signed [31:0] px [3], py [3];
  tcp_out_t tail, out_r, skid_r;
  logic     out_v_r, skid_v_r, tail_v, out_free;
  logic     out_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_spin   <= ONE[17:0];
      cfg_r.sin_spin   <= '0;
      cfg_r.cos_tilt   <= ONE[17:0];
      cfg_r.sin_tilt   <= '0;
      cfg_r.x_scale    <= ONE[30:0];
      cfg_r.y_scale    <= ONE[30:0];
      cfg_r.push_depth <= PUSH_RST[31:0];
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_COS_SPIN:   cfg_r.cos_spin   <= cfg_wdata[17:0];
        CFG_SIN_SPIN:   cfg_r.sin_spin   <= cfg_wdata[17:0];
        CFG_COS_TILT:   cfg_r.cos_tilt   <= cfg_wdata[17:0];
        CFG_SIN_TILT:   cfg_r.sin_tilt   <= cfg_wdata[17:0];
        CFG_X_SCALE:    cfg_r.x_scale    <= cfg_wdata[30:0];
        CFG_Y_SCALE:    cfg_r.y_scale    <= cfg_wdata[30:0];
        CFG_PUSH_DEPTH: cfg_r.push_depth <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en       = !skid_v_r;
  assign in_ready = en;

  tcp_xform #(.FRAC_BITS(FRAC_BITS)) u_xf_a (
    .clk(clk), .en(en), .cfg(cfg_r), .x(in_data.a_x), .y(in_data.a_y), .z(in_data.a_z),
    .xo(vx[0]), .yo(vy[0]), .zo(vz[0]));
  tcp_xform #(.FRAC_BITS(FRAC_BITS)) u_xf_b (
    .clk(clk), .en(en), .cfg(cfg_r), .x(in_data.b_x), .y(in_data.b_y), .z(in_data.b_z),
    .xo(vx[1]), .yo(vy[1]), .zo(vz[1]));
  tcp_xform #(.FRAC_BITS(FRAC_BITS)) u_xf_c (
    .clk(clk), .en(en), .cfg(cfg_r), .x(in_data.c_x), .y(in_data.c_y), .z(in_data.c_z),
    .xo(vx[2]), .yo(vy[2]), .zo(vz[2]));

  logic signed [31:0] va [3], vb [3], vc [3];
  assign va = '{vx[0], vy[0], vz[0]};
  assign vb = '{vx[1], vy[1], vz[1]};
  assign vc = '{vx[2], vy[2], vz[2]};

  tcp_cull u_cull (.clk(clk), .en(en), .a(va), .b(vb), .c(vc), .vis(vis0));

  for (genvar v = 0; v < 3; v++) begin : g_lane
    tcp_proj #(.FRAC_BITS(FRAC_BITS)) u_px (
      .clk(clk), .en(en), .c(vx[v]), .scale(cfg_r.x_scale), .d(vz[v]), .q(px[v]));
    tcp_proj #(.FRAC_BITS(FRAC_BITS)) u_py (
      .clk(clk), .en(en), .c(vy[v]), .scale(cfg_r.y_scale), .d(vz[v]), .q(py[v]));
  end

  // line the cull flag up with the projection lanes
  always_ff @(posedge clk) begin
    if (en) vis_d_r <= {vis_d_r[VIS_DLY-2:0], vis0};
  end

  always_comb begin
    tail.visible = vis_d_r[VIS_DLY-1];
    tail.a_px    = tail.visible ? px[0] : '0;
    tail.a_py    = tail.visible ? py[0] : '0;
    tail.b_px    = tail.visible ? px[1] : '0;
    tail.b_py    = tail.visible ? py[1] : '0;
    tail.c_px    = tail.visible ? px[2] : '0;
    tail.c_py    = tail.visible ? py[2] : '0;
  end

  assign tail_v   = vld_r[PIPE_LAT-1];
  assign out_free = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (en) vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
      if (out_free) begin
        if (skid_v_r) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= en && tail_v;
        end
      end else if (en && tail_v) begin
        // hold the leaving beat until the output frees
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_v_r ? skid_r : tail;
    end else if (en && tail_v) begin
      skid_r <= tail;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  assign out_zero = (out_r.a_px == 32'sd0) && (out_r.a_py == 32'sd0) &&
                    (out_r.b_px == 32'sd0) && (out_r.b_py == 32'sd0) &&
                    (out_r.c_px == 32'sd0) && (out_r.c_py == 32'sd0);

  `TCP_ASSERT_NOW(a_skid_needs_out, !skid_v_r || out_v_r)
  `TCP_ASSERT_NEXT(a_freeze_holds, !en, $stable(vld_r))
  `TCP_ASSERT_NOW(a_hidden_zero, !out_v_r || out_r.visible || out_zero)

endmodule

/* test/tb_triangle_transform_cull_project_top.sv */
module tb_triangle_transform_cull_project_top;
  import tcp_pkg::*;

  localparam int FRAC     = 16;
  localparam int LAT      = 41;
  localparam int LIMIT    = 400000;
  localparam int N_RANDOM = 1830;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  tcp_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  tcp_out_t out_data;
  logic     cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_wdata;

  tcp_out_t expected_tris[$];
  tcp_cfg_t cur_cfg;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       errors;
  longint   cycles;

  triangle_transform_cull_project_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic signed [63:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 64'sd2147483647;
    if (v < -128'sd2147483648) return -64'sd2147483648;
    return v[63:0];
  endfunction

  // round half up at FRAC bits; >>> floors
  function automatic logic signed [63:0] round_q(input logic signed [127:0] v);
    logic signed [127:0] t;
    t = (v + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
    return clamp32(t);
  endfunction

  function automatic void rotate_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
                                        input logic signed [31:0] z,
                                        output logic signed [63:0] rx,
                                        output logic signed [63:0] ry,
                                        output logic signed [63:0] rz);
    logic signed [127:0] cs, ss, ct, st, y1, xx, yy, zz;
    cs = 128'(cur_cfg.cos_spin);
    ss = 128'(cur_cfg.sin_spin);
    ct = 128'(cur_cfg.cos_tilt);
    st = 128'(cur_cfg.sin_tilt);
    xx = 128'(x);
    yy = 128'(y);
    zz = 128'(z);
    rx = round_q(xx * cs - yy * ss);
    y1 = 128'(round_q(xx * ss + yy * cs));
    ry = round_q(y1 * ct - zz * st);
    rz = clamp32(128'(round_q(y1 * st + zz * ct)) + 128'(signed'(cur_cfg.push_depth)));
  endfunction

  function automatic logic signed [31:0] project_coord(input logic signed [63:0] c,
                                                      input logic [30:0] scale,
                                                      input logic signed [63:0] d);
    logic signed [127:0] p, q;
    p = 128'(c) * 128'(signed'({1'b0, scale}));
    if (d == 0) return 32'(round_q(p));
    q = p / 128'(d);
    return 32'(clamp32(q));
  endfunction

  function automatic tcp_out_t project_triangle(input tcp_in_t t);
    tcp_out_t r;
    logic signed [63:0] v[3][3];
    logic signed [127:0] det;
    rotate_vertex(t.a_x, t.a_y, t.a_z, v[0][0], v[0][1], v[0][2]);
    rotate_vertex(t.b_x, t.b_y, t.b_z, v[1][0], v[1][1], v[1][2]);
    rotate_vertex(t.c_x, t.c_y, t.c_z, v[2][0], v[2][1], v[2][2]);
    det = 128'(v[0][0]) * (128'(v[1][1]) * 128'(v[2][2]) - 128'(v[1][2]) * 128'(v[2][1]))
        - 128'(v[0][1]) * (128'(v[1][0]) * 128'(v[2][2]) - 128'(v[1][2]) * 128'(v[2][0]))
        + 128'(v[0][2]) * (128'(v[1][0]) * 128'(v[2][1]) - 128'(v[1][1]) * 128'(v[2][0]));
    r = '0;
    r.visible = det < 0;
    if (r.visible) begin
      r.a_px = project_coord(v[0][0], cur_cfg.x_scale, v[0][2]);
      r.a_py = project_coord(v[0][1], cur_cfg.y_scale, v[0][2]);
      r.b_px = project_coord(v[1][0], cur_cfg.x_scale, v[1][2]);
      r.b_py = project_coord(v[1][1], cur_cfg.y_scale, v[1][2]);
      r.c_px = project_coord(v[2][0], cur_cfg.x_scale, v[2][2]);
      r.c_py = project_coord(v[2][1], cur_cfg.y_scale, v[2][2]);
    end
    return r;
  endfunction

  task automatic write_reg(input tcp_cfg_idx_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_COS_SPIN:   cur_cfg.cos_spin   = value[17:0];
      CFG_SIN_SPIN:   cur_cfg.sin_spin   = value[17:0];
      CFG_COS_TILT:   cur_cfg.cos_tilt   = value[17:0];
      CFG_SIN_TILT:   cur_cfg.sin_tilt   = value[17:0];
      CFG_X_SCALE:    cur_cfg.x_scale    = value[30:0];
      CFG_Y_SCALE:    cur_cfg.y_scale    = value[30:0];
      CFG_PUSH_DEPTH: cur_cfg.push_depth = value;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] cs, input logic [31:0] ss, input logic [31:0] ct,
                           input logic [31:0] st, input logic [31:0] xs, input logic [31:0] ys,
                           input logic [31:0] pd);
    write_reg(CFG_COS_SPIN, cs);
    write_reg(CFG_SIN_SPIN, ss);
    write_reg(CFG_COS_TILT, ct);
    write_reg(CFG_SIN_TILT, st);
    write_reg(CFG_X_SCALE, xs);
    write_reg(CFG_Y_SCALE, ys);
    write_reg(CFG_PUSH_DEPTH, pd);
  endtask

  // valid stays high after the beat; an idle cycle in the next send, or drain, drops it
  task automatic send_triangle(input tcp_in_t t);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_tris.push_back(project_triangle(t));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_tris.size() > 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
      default: return 32'($signed($urandom_range(20 << FRAC)) - (10 << FRAC));
    endcase
  endfunction

  function automatic tcp_in_t rand_triangle();
    tcp_in_t t;
    t.a_x = rand_coord(); t.a_y = rand_coord(); t.a_z = rand_coord();
    t.b_x = rand_coord(); t.b_y = rand_coord(); t.b_z = rand_coord();
    t.c_x = rand_coord(); t.c_y = rand_coord(); t.c_z = rand_coord();
    // swap two vertices now and then to flip the winding
    if ($urandom_range(1)) begin
      {t.b_x, t.b_y, t.b_z, t.c_x, t.c_y, t.c_z} = {t.c_x, t.c_y, t.c_z, t.b_x, t.b_y, t.b_z};
    end
    return t;
  endfunction

  function automatic tcp_in_t make_tri(input int ax, input int ay, input int az, input int bx,
                                       input int by, input int bz, input int cx, input int cy,
                                       input int cz);
    tcp_in_t t;
    t = {32'(ax), 32'(ay), 32'(az), 32'(bx), 32'(by), 32'(bz), 32'(cx), 32'(cy), 32'(cz)};
    return t;
  endfunction

  task automatic test_directed();
    localparam int ONE = 1 << FRAC;
    // culled at default config, then its mirror which is front facing
    send_triangle(make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_triangle(make_tri(0, 0, 0, 0, ONE, 0, ONE, 0, 0));
    // depth lands on zero: undivided path
    send_triangle(make_tri(ONE, ONE, -5 * ONE / 2, 2 * ONE, 0, ONE, 0, 3 * ONE, ONE));
    send_triangle(make_tri(0, -ONE, -5 * ONE / 2, ONE, ONE, -5 * ONE / 2, -ONE, ONE, ONE));
    // degenerate: collinear, zero determinant
    send_triangle(make_tri(0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE));
    send_triangle('0);
    // field extremes and saturation
    send_triangle('1);
    send_triangle({9{32'h7fffffff}});
    send_triangle({9{32'h80000000}});
    send_triangle(make_tri(32'h7fffffff, 0, 1, 0, 32'h7fffffff, 1, 32'h80000000, 32'h80000000, 1));
    send_triangle(make_tri(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 0, 32'h80000000,
                           0, 32'h80000000, 32'h7fffffff));
    send_triangle(make_tri(ONE, 0, -3 * ONE, 0, ONE, -3 * ONE, 0, 0, -2 * ONE));
    drain();
    // extreme config: large scales, negative cosines, extreme push
    write_all(32'h20000, 32'h10000, 32'h30000, 32'h1ffff, 32'h7fffffff, 32'h7fffffff,
              32'h80000000);
    for (int i = 0; i < 6; i++) send_triangle(rand_triangle());
    send_triangle({9{32'h7fffffff}});
    send_triangle(make_tri(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    drain();
    write_all(32'h10000, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h7fffffff);
    send_triangle(make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_triangle(make_tri(0, 0, 0, 0, ONE, 0, ONE, 0, 0));
    drain();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 300 == 299) begin
        drain();
        write_all($urandom, $urandom, $urandom, $urandom, $urandom_range(1) ? $urandom
                  : $urandom_range(4 << FRAC), $urandom_range(1) ? $urandom
                  : $urandom_range(4 << FRAC), $urandom_range(1) ? $urandom
                  : 32'($signed($urandom_range(16 << FRAC)) - (8 << FRAC)));
      end
      if (i == n / 2) begin
        // hold off until the pipe has emptied
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_tris.size() > 0);
      end
      send_triangle(rand_triangle());
    end
  endtask

  always @(posedge clk) begin
    tcp_out_t exp_tri;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_tris.size() == 0) begin
          $display("%0t: unexpected beat, actual %h", $time, out_data);
          errors++;
        end else begin
          exp_tri = expected_tris.pop_front();
          if (out_data !== exp_tri) begin
            $display("%0t: mismatch, expected %h actual %h", $time, exp_tri, out_data);
            errors++;
          end
        end
      end
      out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_triangle_transform_cull_project_top: FAIL");
      $finish;
    end
  end

  initial begin
    errors         = 0;
    cycles         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_COS_SPIN;
    cfg_wdata = '0;
    cur_cfg   = '{cos_spin: 18'h10000, sin_spin: '0, cos_tilt: 18'h10000, sin_tilt: '0,
                  x_scale: 31'h10000, y_scale: 31'h10000, push_depth: 32'd163840};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle_pct  = 23;
    recv_stall_pct = 61;
    test_random(N_RANDOM / 3);
    send_idle_pct  = 61;
    recv_stall_pct = 23;
    test_random(N_RANDOM / 3);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random(N_RANDOM / 3);
    drain();
    if (errors == 0 && expected_tris.size() == 0) begin
      $display("tb_triangle_transform_cull_project_top: PASS");
    end else begin
      $display("tb_triangle_transform_cull_project_top: FAIL");
    end
    $finish;
  end

endmodule

/* triangle_transform_cull_project_top.f */
+incdir+src
src/tcp_pkg.sv
src/tcp_xform.sv
src/tcp_cull.sv
src/tcp_proj.sv
src/triangle_transform_cull_project_top.sv
test/tb_triangle_transform_cull_project_top.sv
